FILE: rtl/rhythmic_motion_run_detector_unit_defines.svh
// assertion macros for the rhythmic motion run detector
// expects clk_i and rst_ni in the scope of each use
`ifndef RHYTHMIC_MOTION_RUN_DETECTOR_UNIT_DEFINES_SVH
`define RHYTHMIC_MOTION_RUN_DETECTOR_UNIT_DEFINES_SVH

// property that holds at every edge outside reset
`define RMRD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition that forces a consequence in the cycle after it
`define RMRD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/rmrd_pkg.sv
// shared types, widths and codes for the rhythmic motion run detector
// no dependencies
package rmrd_pkg;

  localparam int COUNT_WIDTH    = 16;
  localparam int TIME_WIDTH     = 32;
  localparam int CYC_WIDTH      = 32;
  localparam int NEED_WIDTH     = 12;
  localparam int CMP_WIDTH      = (COUNT_WIDTH > NEED_WIDTH ? COUNT_WIDTH : NEED_WIDTH) + 1;
  localparam int PROD_WIDTH     = COUNT_WIDTH + 7;
  localparam int CFG_IDX_WIDTH  = 3;
  localparam int CFG_DATA_WIDTH = 16;

  localparam logic [1:0] CMD_TICK   = 2'd0;
  localparam logic [1:0] CMD_ACTIVE = 2'd1;
  localparam logic [1:0] CMD_IDLE   = 2'd2;

  localparam logic [CFG_IDX_WIDTH-1:0] CFG_AUTO_START    = 3'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_FAST_MODE     = 3'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_GAP_LIMIT     = 3'd2;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_MIN_PERCENT   = 3'd3;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_HEART_CHECK   = 3'd4;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_COOLDOWN      = 3'd5;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_AFTER_SESSION = 3'd6;

  localparam logic [5:0]  AUTO_START_RST    = 6'd0;
  localparam logic        FAST_MODE_RST     = 1'b0;
  localparam logic [7:0]  GAP_LIMIT_RST     = 8'd10;
  localparam logic [6:0]  MIN_PERCENT_RST   = 7'd70;
  localparam logic [9:0]  HEART_CHECK_RST   = 10'd30;
  localparam logic [15:0] COOLDOWN_RST      = 16'(30 * 60);
  localparam logic [15:0] AFTER_SESSION_RST = 16'(10 * 60);

  localparam logic [4:0]            SLOW_LIMIT   = 5'd5;
  localparam logic [4:0]            FAST_LIMIT   = 5'd8;
  localparam logic [NEED_WIDTH-1:0] SECS_PER_MIN = NEED_WIDTH'(60);
  localparam logic [CMP_WIDTH-1:0]  HEART_MARGIN = CMP_WIDTH'(10);
  localparam logic [PROD_WIDTH-1:0] PERCENT_FULL = PROD_WIDTH'(100);

  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};
  localparam logic [CYC_WIDTH-1:0]   CYC_MAX = {CYC_WIDTH{1'b1}};
  localparam logic [15:0]            TOTAL_MAX = 16'hffff;

  typedef struct packed {
    logic [5:0]  auto_start_minutes;
    logic        fast_rhythm_mode;
    logic [7:0]  gap_limit_seconds;
    logic [6:0]  min_rhythmic_percent;
    logic [9:0]  heart_check_after_seconds;
    logic [15:0] cooldown_seconds;
    logic [15:0] after_session_seconds;
  } cfg_t;

  typedef struct packed {
    logic [TIME_WIDTH-1:0]  run_start;
    logic [COUNT_WIDTH-1:0] run_seconds;
    logic [COUNT_WIDTH-1:0] rhythmic_seconds;
    logic [COUNT_WIDTH-1:0] gap_seconds;
    logic [CYC_WIDTH-1:0]   run_cycles;
    logic                   fast_sampling_on;
    logic                   session_active;
    logic [TIME_WIDTH-1:0]  cooldown_until;
  } state_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] now_seconds;
    logic [4:0]  cycle_count;
    logic        is_moving;
    logic        on_foot;
    logic        heart_elevated;
  } item_t;

  typedef struct packed {
    logic        detected;
    logic [31:0] run_start_time;
    logic [15:0] run_cycle_total;
    logic        fast_heart_sampling;
  } result_t;

endpackage

FILE: rtl/rhythmic_motion_run_detector_unit.sv
// top level of the rhythmic motion run detector: config registers, input and result stages
// depends on rmrd_pkg, rmrd_step and rhythmic_motion_run_detector_unit_defines.svh
//
//   channel | handshake              | payload
//   --------+------------------------+-------------------------------------------------
//   in      | in_valid_i / in_stall_o | command, now_seconds, cycle_count, flags
//   out     | out_valid_o / out_stall_i | detected, run_start_time, run_cycle_total, fast
//   cfg     | cfg_we_i               | cfg_index_i, cfg_wdata_i
//
// pipeline: input register, then state update and result register
// one transfer per cycle sustained while out_stall_i is low; the run state is updated
// in the cycle a transfer leaves the input register
// in_stall_o rises only while both stages hold data and out_stall_i is high
// reset clears run state, session and cooldown and loads the config defaults
`include "rhythmic_motion_run_detector_unit_defines.svh"

module rhythmic_motion_run_detector_unit import rmrd_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [1:0]                command_i,
  input  logic [31:0]               now_seconds_i,
  input  logic [4:0]                cycle_count_i,
  input  logic                      is_moving_i,
  input  logic                      on_foot_i,
  input  logic                      heart_elevated_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic                      detected_o,
  output logic [31:0]               run_start_time_o,
  output logic [15:0]               run_cycle_total_o,
  output logic                      fast_heart_sampling_o,
  input  logic                      cfg_we_i,
  input  logic [CFG_IDX_WIDTH-1:0]  cfg_index_i,
  input  logic [CFG_DATA_WIDTH-1:0] cfg_wdata_i
);

  cfg_t    cfg_q, cfg_d;
  state_t  state_q, state_d;
  item_t   item_q;
  result_t result_q, result_d;
  logic    in_valid_q, out_valid_q;
  logic    advance;

  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_AUTO_START:    cfg_d.auto_start_minutes        = cfg_wdata_i[5:0];
        CFG_FAST_MODE:     cfg_d.fast_rhythm_mode          = cfg_wdata_i[0];
        CFG_GAP_LIMIT:     cfg_d.gap_limit_seconds         = cfg_wdata_i[7:0];
        CFG_MIN_PERCENT:   cfg_d.min_rhythmic_percent      = cfg_wdata_i[6:0];
        CFG_HEART_CHECK:   cfg_d.heart_check_after_seconds = cfg_wdata_i[9:0];
        CFG_COOLDOWN:      cfg_d.cooldown_seconds          = cfg_wdata_i;
        CFG_AFTER_SESSION: cfg_d.after_session_seconds     = cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.auto_start_minutes        <= AUTO_START_RST;
      cfg_q.fast_rhythm_mode          <= FAST_MODE_RST;
      cfg_q.gap_limit_seconds         <= GAP_LIMIT_RST;
      cfg_q.min_rhythmic_percent      <= MIN_PERCENT_RST;
      cfg_q.heart_check_after_seconds <= HEART_CHECK_RST;
      cfg_q.cooldown_seconds          <= COOLDOWN_RST;
      cfg_q.after_session_seconds     <= AFTER_SESSION_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  rmrd_step u_step (
    .cfg_i    (cfg_q),
    .state_i  (state_q),
    .item_i   (item_q),
    .state_o  (state_d),
    .result_o (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      in_valid_q  <= (in_valid_i && !in_stall_o) || (in_valid_q && !advance);
      out_valid_q <= advance || (out_valid_q && out_stall_i);
      if (advance) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      item_q.command        <= command_i;
      item_q.now_seconds    <= now_seconds_i;
      item_q.cycle_count    <= cycle_count_i;
      item_q.is_moving      <= is_moving_i;
      item_q.on_foot        <= on_foot_i;
      item_q.heart_elevated <= heart_elevated_i;
    end
    if (advance) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o           = out_valid_q;
  assign detected_o            = result_q.detected;
  assign run_start_time_o      = result_q.run_start_time;
  assign run_cycle_total_o     = result_q.run_cycle_total;
  assign fast_heart_sampling_o = result_q.fast_heart_sampling;

  `RMRD_ASSERT_NEXT(a_detect_drops_run, advance && result_d.detected,
                    state_q.run_seconds == '0, "run kept after detection")
  `RMRD_ASSERT(a_quiet_result, !out_valid_q || result_q.detected ||
               (result_q.run_start_time == '0 && result_q.run_cycle_total == '0),
               "run fields set without detection")
  `RMRD_ASSERT_NEXT(a_held_item, in_valid_q && !advance,
                    in_valid_q && $stable(item_q), "held input item lost or changed")
  `RMRD_ASSERT(a_session_no_run, !state_q.session_active || state_q.run_seconds == '0,
               "run in progress during session")
  `RMRD_ASSERT(a_fast_needs_run, !state_q.fast_sampling_on || state_q.run_seconds != '0,
               "fast sampling without a run")

endmodule

FILE: rtl/rmrd_step.sv
// next-state and result logic for one transfer of the run detector
// depends on rmrd_pkg
module rmrd_step import rmrd_pkg::*; (
  input  cfg_t    cfg_i,
  input  state_t  state_i,
  input  item_t   item_i,
  output state_t  state_o,
  output result_t result_o
);

  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
    return (v == CNT_MAX) ? v : v + COUNT_WIDTH'(1);
  endfunction

  function automatic state_t drop_run(input state_t s);
    state_t r;
    r = s;
    r.run_start        = '0;
    r.run_seconds      = '0;
    r.rhythmic_seconds = '0;
    r.gap_seconds      = '0;
    r.run_cycles       = '0;
    r.fast_sampling_on = 1'b0;
    return r;
  endfunction

  logic [TIME_WIDTH-1:0]  now;
  logic [4:0]             limit;
  logic                   rhythmic;
  logic                   run_open;
  logic [TIME_WIDTH-1:0]  start_new;
  logic [COUNT_WIDTH-1:0] run_inc;
  logic [COUNT_WIDTH-1:0] rhy_inc;
  logic [COUNT_WIDTH-1:0] rhy_new;
  logic [COUNT_WIDTH-1:0] gap_inc;
  logic [CYC_WIDTH:0]     cyc_sum;
  logic [CYC_WIDTH-1:0]   cyc_new;
  logic [NEED_WIDTH-1:0]  need_full;
  logic [NEED_WIDTH-1:0]  needed;
  logic                   late;
  logic [PROD_WIDTH-1:0]  rhy_prod;
  logic [PROD_WIDTH-1:0]  run_prod;
  logic                   meets;
  logic                   gap_over;
  logic                   tick_live;

  assign now       = TIME_WIDTH'(item_i.now_seconds);
  assign limit     = cfg_i.fast_rhythm_mode ? FAST_LIMIT : SLOW_LIMIT;
  assign rhythmic  = item_i.is_moving && (item_i.cycle_count != 5'd0) &&
                     (item_i.cycle_count <= limit);
  assign run_open  = (state_i.run_seconds != '0);
  assign start_new = run_open ? state_i.run_start : now;
  assign run_inc   = sat_inc(state_i.run_seconds);
  assign rhy_inc   = sat_inc(state_i.rhythmic_seconds);
  assign rhy_new   = rhythmic ? rhy_inc : state_i.rhythmic_seconds;
  assign gap_inc   = sat_inc(state_i.gap_seconds);
  assign gap_over  = CMP_WIDTH'(gap_inc) > CMP_WIDTH'(cfg_i.gap_limit_seconds);
  assign cyc_sum   = {1'b0, state_i.run_cycles} + (CYC_WIDTH + 1)'(item_i.cycle_count);
  assign cyc_new   = cyc_sum[CYC_WIDTH] ? CYC_MAX : cyc_sum[CYC_WIDTH-1:0];

  assign need_full = NEED_WIDTH'(cfg_i.auto_start_minutes) * SECS_PER_MIN;
  assign late      = CMP_WIDTH'(run_inc) >
                     (CMP_WIDTH'(cfg_i.heart_check_after_seconds) + HEART_MARGIN);
  assign needed    = (late && item_i.heart_elevated) ? (need_full >> 1) : need_full;
  assign rhy_prod  = PROD_WIDTH'(rhy_new) * PERCENT_FULL;
  assign run_prod  = PROD_WIDTH'(run_inc) * PROD_WIDTH'(cfg_i.min_rhythmic_percent);
  assign meets     = (CMP_WIDTH'(run_inc) >= CMP_WIDTH'(needed)) && (rhy_prod >= run_prod);

  assign tick_live = (cfg_i.auto_start_minutes != 6'd0) && !state_i.session_active &&
                     !(now < state_i.cooldown_until);

  always_comb begin
    state_o  = state_i;
    result_o = '0;
    unique case (item_i.command)
      CMD_TICK: begin
        if (tick_live) begin
          if (item_i.on_foot) begin
            state_o = drop_run(state_i);
          end else if (run_open || rhythmic) begin
            state_o.run_start   = start_new;
            state_o.run_seconds = run_inc;
            state_o.run_cycles  = cyc_new;
            if (rhythmic) begin
              state_o.rhythmic_seconds = rhy_inc;
              state_o.gap_seconds      = '0;
            end else begin
              state_o.gap_seconds = gap_inc;
            end
            if (!rhythmic && gap_over) begin
              state_o = drop_run(state_o);
            end else begin
              if (CMP_WIDTH'(run_inc) == CMP_WIDTH'(cfg_i.heart_check_after_seconds)) begin
                state_o.fast_sampling_on = 1'b1;
              end
              if (meets) begin
                result_o.detected        = 1'b1;
                result_o.run_start_time  = 32'(start_new);
                result_o.run_cycle_total = (|cyc_new[CYC_WIDTH-1:16]) ? TOTAL_MAX
                                                                      : cyc_new[15:0];
                state_o.cooldown_until   = now + TIME_WIDTH'(cfg_i.cooldown_seconds);
                state_o = drop_run(state_o);
              end
            end
          end
        end
      end
      CMD_ACTIVE: begin
        state_o = drop_run(state_i);
        state_o.session_active = 1'b1;
      end
      CMD_IDLE: begin
        state_o.session_active = 1'b0;
        state_o.cooldown_until = now + TIME_WIDTH'(cfg_i.after_session_seconds);
      end
      default: begin
      end
    endcase
    result_o.fast_heart_sampling = state_o.fast_sampling_on;
  end

endmodule
